/* design/ecc_pkg.sv */
// Shared types, constants and the month table for the epoch calendar converter.
// Depends on nothing; every other file in the design refers to it by scoped names.
`default_nettype none

package ecc_pkg;

  // Opcode values of an input item.
  localparam logic OP_TO_SECS = 1'b0;
  localparam logic OP_TO_DATE = 1'b1;

  localparam logic [11:0] BASE_YEAR = 12'd2000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] epoch_in;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] epoch_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
    logic        bad_input;
  } out_item_t;

  // Result of the date to seconds pipeline.
  typedef struct packed {
    logic [31:0] epoch;
    logic        bad;
  } d2s_res_t;

  // Result of the seconds to date pipeline.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } s2d_res_t;

  // Day of year on which month idx+1 starts, in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/ecc_date2sec.sv */
// Four-stage pipeline that turns a calendar date and time into seconds since 2000.
// Uses types and the month table from ecc_pkg; the last multiply feeds the caller's register.
`default_nettype none

module ecc_date2sec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ecc_pkg::in_item_t in_item,
  output logic              out_valid,
  output ecc_pkg::d2s_res_t out_res
);

  // Stage 1: range check and the divisions by 100 (multiply by 5243, shift by 19).
  logic [11:0] n_year;
  logic [24:0] y_prod;
  logic [24:0] n_prod;
  logic        bad_nxt;

  always_comb begin
    n_year  = in_item.year_in - 12'd1;
    y_prod  = {13'd0, in_item.year_in} * 25'd5243;
    n_prod  = {13'd0, n_year} * 25'd5243;
    bad_nxt = (in_item.month_in == 4'd0) || (in_item.month_in > 4'd12) ||
              (in_item.day_in == 5'd0) || (in_item.hour_in > 5'd23) ||
              (in_item.minute_in > 6'd59) || (in_item.second_in > 6'd59);
  end

  logic        v1_r;
  logic        bad1_r;
  logic [11:0] y1_r;
  logic [11:0] n1_r;
  logic [5:0]  y100_1_r;
  logic [5:0]  n100_1_r;
  logic [3:0]  mon1_r;
  logic [4:0]  day1_r;
  logic [4:0]  hr1_r;
  logic [5:0]  min1_r;
  logic [5:0]  sec1_r;

  // Stage 2: leap rule and the leap count through the previous year.
  logic [11:0] ymod100;
  logic        leap_nxt;
  logic [9:0]  ln_nxt;

  always_comb begin
    ymod100  = y1_r - ({6'd0, y100_1_r} * 12'd100);
    leap_nxt = ((y1_r[1:0] == 2'd0) && (ymod100 != 12'd0)) ||
               ((ymod100 == 12'd0) && (y100_1_r[1:0] == 2'd0));
    ln_nxt   = n1_r[11:2] - {4'd0, n100_1_r} + {6'd0, n100_1_r[5:2]};
  end

  logic        v2_r;
  logic        bad2_r;
  logic        leap2_r;
  logic        later2_r;
  logic [11:0] y2_r;
  logic [9:0]  ln2_r;
  logic [3:0]  mon2_r;
  logic [4:0]  day2_r;
  logic [4:0]  hr2_r;
  logic [5:0]  min2_r;
  logic [5:0]  sec2_r;

  // Stage 3: days from whole years and days within the year.
  // 484 is the number of leap years from year 1 through 1999.
  logic [11:0] yd;
  logic [19:0] days_y_nxt;
  logic [8:0]  mdays_nxt;

  always_comb begin
    yd = y2_r - ecc_pkg::BASE_YEAR;
    if (later2_r) begin
      days_y_nxt = ({8'd0, yd} * 20'd365) + {10'd0, ln2_r} - 20'd484;
    end else begin
      days_y_nxt = 20'd0;
    end
    mdays_nxt = ecc_pkg::month_start(mon2_r - 4'd1) +
                {8'd0, (mon2_r > 4'd2) && leap2_r} +
                {4'd0, day2_r} - 9'd1;
  end

  logic        v3_r;
  logic        bad3_r;
  logic [19:0] days_y3_r;
  logic [8:0]  mdays3_r;
  logic [4:0]  hr3_r;
  logic [5:0]  min3_r;
  logic [5:0]  sec3_r;

  // Stage 4: total days and seconds within the day.
  logic [19:0] days_nxt;
  logic [16:0] hms_nxt;

  always_comb begin
    days_nxt = days_y3_r + {11'd0, mdays3_r};
    hms_nxt  = ({12'd0, hr3_r} * 17'd3600) + ({11'd0, min3_r} * 17'd60) +
               {11'd0, sec3_r};
  end

  logic        v4_r;
  logic        bad4_r;
  logic [19:0] days4_r;
  logic [16:0] hms4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    bad1_r    <= bad_nxt;
    y1_r      <= in_item.year_in;
    n1_r      <= n_year;
    y100_1_r  <= y_prod[24:19];
    n100_1_r  <= n_prod[24:19];
    mon1_r    <= in_item.month_in;
    day1_r    <= in_item.day_in;
    hr1_r     <= in_item.hour_in;
    min1_r    <= in_item.minute_in;
    sec1_r    <= in_item.second_in;

    bad2_r    <= bad1_r;
    leap2_r   <= leap_nxt;
    later2_r  <= (y1_r > ecc_pkg::BASE_YEAR);
    y2_r      <= y1_r;
    ln2_r     <= ln_nxt;
    mon2_r    <= mon1_r;
    day2_r    <= day1_r;
    hr2_r     <= hr1_r;
    min2_r    <= min1_r;
    sec2_r    <= sec1_r;

    bad3_r    <= bad2_r;
    days_y3_r <= days_y_nxt;
    mdays3_r  <= mdays_nxt;
    hr3_r     <= hr2_r;
    min3_r    <= min2_r;
    sec3_r    <= sec2_r;

    bad4_r    <= bad3_r;
    days4_r   <= days_nxt;
    hms4_r    <= hms_nxt;
  end

  // The seconds count wraps modulo 2^32 for large years.
  logic [31:0] day_secs;

  always_comb begin
    day_secs      = {12'd0, days4_r} * 32'd86400;
    out_valid     = v4_r;
    out_res.bad   = bad4_r;
    out_res.epoch = bad4_r ? 32'd0 : (day_secs + {15'd0, hms4_r});
  end

endmodule

`default_nettype wire

/* design/ecc_sec2date.sv */
// Four-stage pipeline that splits seconds since 2000 into date, time and weekday.
// Uses types and the month table from ecc_pkg; the month search feeds the caller's register.
`default_nettype none

module ecc_sec2date (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ecc_pkg::in_item_t in_item,
  output logic              out_valid,
  output ecc_pkg::s2d_res_t out_res
);

  // First day of month idx+1, with the leap day counted from March on.
  function automatic logic [8:0] first_day(input logic [3:0] idx, input logic leap);
    logic [8:0] d;
    d = ecc_pkg::month_start(idx);
    if (leap && (idx >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  // Stage 1: whole days. 86400 = 128 * 675; the division by 675 is a
  // multiply by the rounded-up reciprocal 2^35 / 675.
  logic [50:0] dprod;

  always_comb begin
    dprod = {26'd0, in_item.epoch_in[31:7]} * 51'd50903317;
  end

  logic        v1_r;
  logic [16:0] ep1_r;
  logic [15:0] dq1_r;

  // Stage 2: seconds in the day, a year estimate (days / 365) and (days + 6) / 7.
  logic [16:0] rem_nxt;
  logic [31:0] est_prod;
  logic [16:0] wx1;
  logic [31:0] wprod;

  always_comb begin
    rem_nxt  = ep1_r - ({1'b0, dq1_r} * 17'd86400);
    est_prod = {16'd0, dq1_r} * 32'd45965;
    wx1      = {1'b0, dq1_r} + 17'd6;
    wprod    = {15'd0, wx1} * 32'd74899;
  end

  logic        v2_r;
  logic [16:0] rem2_r;
  logic [15:0] dq2_r;
  logic [7:0]  est2_r;
  logic [12:0] wq2_r;

  // Stage 3: hour and minute of day, the first day of the estimated year,
  // and the weekday. 2000-01-01 was a Saturday, hence the offset of six.
  logic [25:0] hprod;
  logic [29:0] mprod;
  logic [7:0]  est_p3;
  logic [16:0] start_nxt;
  logic [16:0] wx2;
  logic [16:0] wrem;

  always_comb begin
    hprod     = {13'd0, rem2_r[16:4]} * 26'd4661;
    mprod     = {15'd0, rem2_r[16:2]} * 30'd17477;
    est_p3    = est2_r + 8'd3;
    // Leap years from 2000 up to the estimate: every fourth year, but not 2100.
    start_nxt = ({9'd0, est2_r} * 17'd365) + {11'd0, est_p3[7:2]} -
                {16'd0, est2_r >= 8'd101};
    wx2       = {1'b0, dq2_r} + 17'd6;
    wrem      = wx2 - ({4'd0, wq2_r} * 17'd7);
  end

  logic        v3_r;
  logic [16:0] rem3_r;
  logic [4:0]  hour3_r;
  logic [10:0] mday3_r;
  logic [16:0] start3_r;
  logic [7:0]  est3_r;
  logic [15:0] dq3_r;
  logic [2:0]  wd3_r;

  // Stage 4: minute and second, and the year estimate corrected by at most one.
  logic [10:0] min_full;
  logic [16:0] sec_full;
  logic        corr;
  logic [7:0]  t_nxt;
  logic        leap_nxt;
  logic [16:0] doy_full;

  always_comb begin
    min_full = mday3_r - ({6'd0, hour3_r} * 11'd60);
    sec_full = rem3_r - ({6'd0, mday3_r} * 17'd60);
    corr     = start3_r > {1'b0, dq3_r};
    t_nxt    = corr ? (est3_r - 8'd1) : est3_r;
    leap_nxt = (t_nxt[1:0] == 2'd0) && (t_nxt != 8'd100);
    doy_full = {1'b0, dq3_r} - start3_r;
    if (corr) begin
      doy_full = doy_full + 17'd365 + {16'd0, leap_nxt};
    end
  end

  logic        v4_r;
  logic [7:0]  t4_r;
  logic        leap4_r;
  logic [8:0]  doy4_r;
  logic [4:0]  hour4_r;
  logic [5:0]  min4_r;
  logic [5:0]  sec4_r;
  logic [2:0]  wd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ep1_r    <= in_item.epoch_in[16:0];
    dq1_r    <= dprod[50:35];

    rem2_r   <= rem_nxt;
    dq2_r    <= dq1_r;
    est2_r   <= est_prod[31:24];
    wq2_r    <= wprod[31:19];

    rem3_r   <= rem2_r;
    hour3_r  <= hprod[24:20];
    mday3_r  <= mprod[28:18];
    start3_r <= start_nxt;
    est3_r   <= est2_r;
    dq3_r    <= dq2_r;
    wd3_r    <= wrem[2:0];

    t4_r     <= t_nxt;
    leap4_r  <= leap_nxt;
    doy4_r   <= doy_full[8:0];
    hour4_r  <= hour3_r;
    min4_r   <= min_full[5:0];
    sec4_r   <= sec_full[5:0];
    wd4_r    <= wd3_r;
  end

  // Month search: the month starts rise, so the last one reached wins.
  logic [3:0] mon_idx;
  logic [8:0] mstart;
  logic [8:0] day_full;

  always_comb begin
    mon_idx = 4'd0;
    mstart  = 9'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy4_r >= first_day(4'(k), leap4_r)) begin
        mon_idx = 4'(k);
        mstart  = first_day(4'(k), leap4_r);
      end
    end
    day_full = doy4_r - mstart + 9'd1;

    out_valid       = v4_r;
    out_res.year    = ecc_pkg::BASE_YEAR + {4'd0, t4_r};
    out_res.month   = mon_idx + 4'd1;
    out_res.day     = day_full[4:0];
    out_res.hour    = hour4_r;
    out_res.minute  = min4_r;
    out_res.second  = sec4_r;
    out_res.weekday = wd4_r;
  end

endmodule

`default_nettype wire

/* design/epoch_calendar_converter.sv */
// A result is registered on the out_ ports after its item passes through a conversion pipeline.
// Throughput: one item per cycle; both conversion pipelines take a new item every cycle.
// Results cannot be held off, and out_valid marks each one for exactly one cycle.
// busy is high only while rst_n is low; reset clears every valid bit in the pipelines.
// Top level: instantiates ecc_date2sec and ecc_sec2date and registers the chosen result.
`default_nettype none

module epoch_calendar_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ecc_pkg::in_item_t  in_data,
  output logic               busy,
  output logic               out_valid,
  output ecc_pkg::out_item_t out_data
);

  logic              accept;
  logic              d2s_valid;
  logic              s2d_valid;
  ecc_pkg::d2s_res_t d2s_res;
  ecc_pkg::s2d_res_t s2d_res;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  ecc_date2sec u_date2sec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept && (in_data.opcode == ecc_pkg::OP_TO_SECS)),
    .in_item   (in_data),
    .out_valid (d2s_valid),
    .out_res   (d2s_res)
  );

  ecc_sec2date u_sec2date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept && (in_data.opcode == ecc_pkg::OP_TO_DATE)),
    .in_item   (in_data),
    .out_valid (s2d_valid),
    .out_res   (s2d_res)
  );

  // Fields that do not belong to the item's direction read as zero.
  ecc_pkg::out_item_t out_nxt;

  always_comb begin
    out_nxt = '0;
    if (d2s_valid) begin
      out_nxt.epoch_out = d2s_res.epoch;
      out_nxt.bad_input = d2s_res.bad;
    end else if (s2d_valid) begin
      out_nxt.year_out    = s2d_res.year;
      out_nxt.month_out   = s2d_res.month;
      out_nxt.day_out     = s2d_res.day;
      out_nxt.hour_out    = s2d_res.hour;
      out_nxt.minute_out  = s2d_res.minute;
      out_nxt.second_out  = s2d_res.second;
      out_nxt.weekday_out = s2d_res.weekday;
    end
  end

  logic               out_valid_r;
  ecc_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2s_valid | s2d_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* design/ecc_checker.sv */
// Port-level checks on the epoch calendar converter: result timing and field ranges.
// Uses ecc_pkg types; bound to epoch_calendar_converter by the statement at the end.
`default_nettype none

module ecc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ecc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input ecc_pkg::out_item_t out_data
);

  logic acc;
  logic acc_date;
  logic acc_bad;

  assign acc      = start && !busy;
  assign acc_date = acc && (in_data.opcode == ecc_pkg::OP_TO_SECS);
  assign acc_bad  = acc_date &&
                    ((in_data.month_in == 4'd0) || (in_data.month_in > 4'd12) ||
                     (in_data.day_in == 5'd0) || (in_data.hour_in > 5'd23) ||
                     (in_data.minute_in > 6'd59) || (in_data.second_in > 6'd59));

  // Every accepted item gives exactly one result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##5 out_valid)
    else $error("accepted item gave no result after five cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 5))
    else $error("result without a matching accepted item");

  // A date item with a field out of range reports the flag and epoch zero.
  a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(acc_date, 5)) |->
      ((out_data.bad_input == $past(acc_bad, 5)) &&
       (!out_data.bad_input || (out_data.epoch_out == 32'd0)) &&
       (out_data.year_out == 12'd0) && (out_data.weekday_out == 3'd0)))
    else $error("date item result fields inconsistent");

  // A seconds item gives a calendar date with every field in range.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(acc_date, 5)) |->
      ((out_data.month_out >= 4'd1) && (out_data.month_out <= 4'd12) &&
       (out_data.day_out >= 5'd1) && (out_data.hour_out <= 5'd23) &&
       (out_data.minute_out <= 6'd59) && (out_data.second_out <= 6'd59) &&
       (out_data.weekday_out <= 3'd6) && (out_data.year_out >= 12'd2000) &&
       (out_data.year_out <= 12'd2136) && !out_data.bad_input &&
       (out_data.epoch_out == 32'd0)))
    else $error("seconds item result field out of range");

endmodule

bind epoch_calendar_converter ecc_checker u_ecc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
